// ===== design/sparse_disk_block_translator_top_macros.svh =====
// assertion macros used by the sparse disk block translator datapath
`ifndef SPARSE_DISK_BLOCK_TRANSLATOR_TOP_MACROS_SVH
`define SPARSE_DISK_BLOCK_TRANSLATOR_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define SDBT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SDBT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/sdbt_pkg.sv =====
// shared types, constants and helpers of the sparse disk block translator
package sdbt_pkg;

    localparam int SECTOR_W  = 32;
    localparam int DSEC_W    = 41;
    localparam int RUN_W     = 16;
    localparam int IDX_W     = 12;
    localparam int VAL_W     = 32;
    localparam int TOTAL_W   = 28;
    localparam int SHIFT_W   = 5;
    localparam int TENT_W    = 13;
    localparam int TBO_W     = 48;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 48;
    localparam int BMAP_W    = 20;

    localparam logic [VAL_W-1:0]   UNALLOC     = 32'hFFFF_FFFF;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd12;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_BAD   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_UNALLOC = 2'd1,
        STS_RANGE   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CFG_TOTAL = 2'd0,
        CFG_SHIFT = 2'd1,
        CFG_TENT  = 2'd2,
        CFG_TBO   = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic capture;
        logic execute;
    } t_dp_cmd;

    typedef struct packed {
        logic out_stall;
    } t_dp_stat;

    // bitmap sectors in front of each block
    function automatic logic [BMAP_W-1:0] bitmap_sectors(input logic [SHIFT_W-1:0] shift);
        logic [BMAP_W-1:0] res;
        if (shift < 5'd3) begin
            res = '0;
        end else if (shift <= 5'd12) begin
            res = BMAP_W'(1);
        end else begin
            res = BMAP_W'(1) << (shift - 5'd12);
        end
        return res;
    endfunction

endpackage

// ===== design/sdbt_ifs.sv =====
// handshake channel interfaces: request, response and register write
interface sdbt_req_if import sdbt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [1:0]          action;
    logic [SECTOR_W-1:0] sector;
    logic [RUN_W-1:0]    request_sectors;
    logic [IDX_W-1:0]    load_index;
    logic [VAL_W-1:0]    load_value;

    modport source (output valid, action, sector, request_sectors, load_index, load_value,
                    input ready);
    modport sink   (input valid, action, sector, request_sectors, load_index, load_value,
                    output ready);
endinterface

interface sdbt_rsp_if import sdbt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [DSEC_W-1:0] data_sector;
    logic [RUN_W-1:0]  run_sectors;
    logic              write_bitmap;
    logic [DSEC_W-1:0] bitmap_sector;
    logic              block_allocated;
    logic [IDX_W-1:0]  table_index;
    logic [VAL_W-1:0]  table_value;
    logic [DSEC_W-1:0] footer_sector;

    modport source (output valid, status, data_sector, run_sectors, write_bitmap,
                    bitmap_sector, block_allocated, table_index, table_value, footer_sector,
                    input ready);
    modport sink   (input valid, status, data_sector, run_sectors, write_bitmap,
                    bitmap_sector, block_allocated, table_index, table_value, footer_sector,
                    output ready);
endinterface

interface sdbt_cfg_if import sdbt_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/sdbt_ram.sv =====
// generic single-write, single-read ram with registered read data
module sdbt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/sdbt_ctrl.sv =====
// controller: takes one request, then runs its execute step when the output is free
module sdbt_ctrl import sdbt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                // table word is back from the ram; wait only for a free output slot
                if (!i_stat.out_stall) begin
                    o_cmd.execute = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/sdbt_dpath.sv =====
// datapath: config registers, table ram, free pointer, bitmap tracking, output register
module sdbt_dpath import sdbt_pkg::*; #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    output t_dp_stat   o_stat,
    sdbt_req_if.sink   i_req,
    sdbt_rsp_if.source o_rsp,
    sdbt_cfg_if.sink   i_cfg
);

`include "sparse_disk_block_translator_top_macros.svh"

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [SECTOR_W:0] DEPTH_X = (SECTOR_W+1)'(TABLE_DEPTH);

    // configuration
    logic [TOTAL_W-1:0] r_total;
    logic [SHIFT_W-1:0] r_shift;
    logic [TENT_W-1:0]  r_tent;
    logic [TBO_W-1:0]   r_tbo;

    // allocation state
    logic [DSEC_W-1:0] r_free;
    logic [DSEC_W-1:0] n_free;
    logic [VAL_W-1:0]  r_lbm;
    logic [VAL_W-1:0]  n_lbm;
    logic              r_lbm_v;
    logic              n_lbm_v;

    // request context captured at the transfer
    t_action           r_act;
    logic              r_oor;
    logic              r_idx_bad;
    logic              r_lidx_bad;
    logic [AW-1:0]     r_addr;
    logic [IDX_W-1:0]  r_idx12;
    logic [VAL_W-1:0]  r_base;
    logic [VAL_W-1:0]  r_step;
    logic [RUN_W-1:0]  r_run;
    logic [VAL_W-1:0]  r_lval;
    logic [DSEC_W-1:0] r_cand_tbl;
    logic [33:0]       r_cand_lv;

    // output register
    logic              r_ov;
    t_status           r_sts;
    logic [DSEC_W-1:0] r_dsec;
    logic [RUN_W-1:0]  r_orun;
    logic              r_wbm;
    logic [DSEC_W-1:0] r_bsec_out;
    logic              r_alloc;
    logic [IDX_W-1:0]  r_tidx;
    logic [VAL_W-1:0]  r_tval;
    logic [DSEC_W-1:0] r_foot;

    // accept-side logic
    logic [VAL_W-1:0]    c_bsec;
    logic [VAL_W-1:0]    c_within;
    logic [VAL_W-1:0]    c_idx;
    logic [VAL_W-1:0]    c_room;
    logic [RUN_W-1:0]    c_run;
    logic [BMAP_W-1:0]   c_bmap;
    logic [TBO_W:0]      c_tbl_end;
    logic [VAL_W-1:0]    c_lidx32;
    logic [AW-1:0]       c_addr;
    logic [AW-1:0]       ram_raddr;
    logic [VAL_W-1:0]    ram_rdata;

    // execute-side logic
    t_status           e_sts;
    logic [DSEC_W-1:0] e_dsec;
    logic [RUN_W-1:0]  e_run;
    logic              e_wbm;
    logic [DSEC_W-1:0] e_bsec;
    logic              e_alloc;
    logic [IDX_W-1:0]  e_tidx;
    logic [VAL_W-1:0]  e_tval;
    logic [DSEC_W-1:0] e_foot;
    logic              e_we;
    logic [VAL_W-1:0]  e_wdata;
    logic [DSEC_W-1:0] e_max1;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_shift <= SHIFT_RESET;
            r_tent  <= '0;
            r_tbo   <= '0;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_TOTAL: r_total <= i_cfg.data[TOTAL_W-1:0];
                CFG_SHIFT: r_shift <= i_cfg.data[SHIFT_W-1:0];
                CFG_TENT:  r_tent  <= i_cfg.data[TENT_W-1:0];
                CFG_TBO:   r_tbo   <= i_cfg.data[TBO_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        c_bsec    = VAL_W'(1) << r_shift;
        c_within  = i_req.sector & (c_bsec - VAL_W'(1));
        c_idx     = i_req.sector >> r_shift;
        c_room    = c_bsec - c_within;
        c_run     = (c_room > VAL_W'(i_req.request_sectors)) ? i_req.request_sectors
                                                             : c_room[RUN_W-1:0];
        c_bmap    = bitmap_sectors(r_shift);
        // first whole sector after the table
        c_tbl_end = (TBO_W+1)'(r_tbo) + (TBO_W+1)'({r_tent, 2'b00}) + (TBO_W+1)'(511);
        c_lidx32  = VAL_W'(i_req.load_index);
        c_addr    = (t_action'(i_req.action) == ACT_LOAD) ? c_lidx32[AW-1:0] : c_idx[AW-1:0];
    end

    // hold the read address while the request waits so the table word stays put
    assign ram_raddr = i_cmd.capture ? c_addr : r_addr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_act      <= t_action'(i_req.action);
            r_oor      <= i_req.sector >= VAL_W'(r_total);
            r_idx_bad  <= (c_idx >= VAL_W'(r_tent)) || ({1'b0, c_idx} >= DEPTH_X);
            r_lidx_bad <= {1'b0, c_lidx32} >= DEPTH_X;
            r_addr     <= c_addr;
            r_idx12    <= c_idx[IDX_W-1:0];
            r_base     <= VAL_W'(c_bmap) + c_within;
            r_step     <= c_bsec + VAL_W'(c_bmap);
            r_run      <= c_run;
            r_lval     <= i_req.load_value;
            r_cand_tbl <= DSEC_W'(c_tbl_end[TBO_W:9]);
            r_cand_lv  <= 34'(i_req.load_value) + 34'(c_bmap) + 34'(c_bsec);
        end
    end

    sdbt_ram #(
        .WIDTH (VAL_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (r_addr),
        .i_wdata (e_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        e_sts   = STS_OK;
        e_dsec  = '0;
        e_run   = '0;
        e_wbm   = 1'b0;
        e_bsec  = '0;
        e_alloc = 1'b0;
        e_tidx  = '0;
        e_tval  = '0;
        e_foot  = '0;
        e_we    = 1'b0;
        e_wdata = r_lval;
        e_max1  = (r_cand_tbl > r_free) ? r_cand_tbl : r_free;
        n_free  = r_free;
        n_lbm   = r_lbm;
        n_lbm_v = r_lbm_v;
        case (r_act)
            ACT_LOAD: begin
                if (r_lidx_bad) begin
                    e_sts = STS_RANGE;
                end else begin
                    e_we   = i_cmd.execute;
                    n_free = e_max1;
                    if (r_lval != UNALLOC && DSEC_W'(r_cand_lv) > e_max1) begin
                        n_free = DSEC_W'(r_cand_lv);
                    end
                end
            end
            ACT_READ, ACT_WRITE: begin
                if (r_oor) begin
                    e_sts = STS_RANGE;
                end else if (r_idx_bad) begin
                    if (r_act == ACT_READ) begin
                        e_sts = STS_UNALLOC;
                        e_run = r_run;
                    end else begin
                        e_sts = STS_RANGE;
                    end
                end else if (ram_rdata != UNALLOC) begin
                    e_run  = r_run;
                    e_dsec = DSEC_W'(ram_rdata) + DSEC_W'(r_base);
                    e_bsec = DSEC_W'(ram_rdata);
                    if (r_act == ACT_WRITE && (!r_lbm_v || r_lbm != ram_rdata)) begin
                        e_wbm   = 1'b1;
                        n_lbm   = ram_rdata;
                        n_lbm_v = 1'b1;
                    end
                end else if (r_act == ACT_READ) begin
                    e_sts = STS_UNALLOC;
                    e_run = r_run;
                end else if (r_free >= DSEC_W'(UNALLOC)) begin
                    // free pointer no longer fits a table entry
                    e_sts = STS_RANGE;
                end else begin
                    e_run   = r_run;
                    e_we    = i_cmd.execute;
                    e_wdata = r_free[VAL_W-1:0];
                    n_free  = r_free + DSEC_W'(r_step);
                    e_dsec  = r_free + DSEC_W'(r_base);
                    e_wbm   = 1'b1;
                    e_bsec  = r_free;
                    e_alloc = 1'b1;
                    e_tidx  = r_idx12;
                    e_tval  = r_free[VAL_W-1:0];
                    e_foot  = n_free;
                end
            end
            default: begin
                e_sts = STS_RANGE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free  <= '0;
            r_lbm   <= '0;
            r_lbm_v <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cmd.execute) begin
                r_free  <= n_free;
                r_lbm   <= n_lbm;
                r_lbm_v <= n_lbm_v;
                r_ov    <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_sts      <= e_sts;
            r_dsec     <= e_dsec;
            r_orun     <= e_run;
            r_wbm      <= e_wbm;
            r_bsec_out <= e_bsec;
            r_alloc    <= e_alloc;
            r_tidx     <= e_tidx;
            r_tval     <= e_tval;
            r_foot     <= e_foot;
        end
    end

    assign o_stat.out_stall      = r_ov && !o_rsp.ready;
    assign o_rsp.valid           = r_ov;
    assign o_rsp.status          = r_sts;
    assign o_rsp.data_sector     = r_dsec;
    assign o_rsp.run_sectors     = r_orun;
    assign o_rsp.write_bitmap    = r_wbm;
    assign o_rsp.bitmap_sector   = r_bsec_out;
    assign o_rsp.block_allocated = r_alloc;
    assign o_rsp.table_index     = r_tidx;
    assign o_rsp.table_value     = r_tval;
    assign o_rsp.footer_sector   = r_foot;

    `SDBT_ASSERT_NOW(a_free_monotonic, i_clk, i_rst_n, $past(i_rst_n), r_free >= $past(r_free), "free pointer moved backward")
    `SDBT_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, i_cmd.execute, !(r_ov && !o_rsp.ready), "result overwritten before transfer")
    `SDBT_ASSERT_NOW(a_alloc_shape, i_clk, i_rst_n, r_ov && r_alloc, r_wbm && r_sts == STS_OK && r_foot > r_bsec_out, "inconsistent allocation result")

endmodule

// ===== design/sparse_disk_block_translator_top.sv =====
// top level of the sparse disk block translator: controller, datapath and channel glue
// a request is captured in the idle state; the execute step registers its result
// a new request is taken only back in the idle state, after the execute step of the last
// a result waiting on the output holds off only the execute step of the next request
// reset: synchronous active low; clears config to defaults, free pointer and bitmap record
// the allocation table is not cleared; entries must be loaded before use
module sparse_disk_block_translator_top import sdbt_pkg::*; #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sdbt_req_if.sink   i_req,
    sdbt_rsp_if.source o_rsp,
    sdbt_cfg_if.sink   i_cfg
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    logic     in_ready;

    assign i_req.ready = in_ready;

    sdbt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    sdbt_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (dp_cmd),
        .o_stat  (dp_stat),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_cfg   (i_cfg)
    );

endmodule

// ===== tb/sparse_disk_block_translator_top_tb.sv =====
// testbench of the sparse disk block translator: directed and random requests checked by a model
`timescale 1ns / 100ps

module sparse_disk_block_translator_top_tb;
    import sdbt_pkg::*;

    localparam int TBL_DEPTH = 4096;

    typedef struct packed {
        t_action          action;
        logic [SECTOR_W-1:0] sector;
        logic [RUN_W-1:0] request;
        logic [IDX_W-1:0] load_index;
        logic [VAL_W-1:0] load_value;
    } t_req;

    typedef struct packed {
        t_status           status;
        logic [DSEC_W-1:0] data_sector;
        logic [RUN_W-1:0]  run_sectors;
        logic              write_bitmap;
        logic [DSEC_W-1:0] bitmap_sector;
        logic              block_allocated;
        logic [IDX_W-1:0]  table_index;
        logic [VAL_W-1:0]  table_value;
        logic [DSEC_W-1:0] footer_sector;
    } t_rsp;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sdbt_req_if req_bus ();
    sdbt_rsp_if rsp_bus ();
    sdbt_cfg_if cfg_bus ();

    sparse_disk_block_translator_top #(.TABLE_DEPTH(TBL_DEPTH)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus),
        .i_cfg   (cfg_bus)
    );

    always #4 i_clk = ~i_clk;

    // model copy of the block state and registers
    logic [VAL_W-1:0]   blk_table [TBL_DEPTH];
    bit                 loaded [TBL_DEPTH];
    logic [DSEC_W-1:0]  free_ptr = '0;
    logic [DSEC_W-1:0]  last_bmp = '0;
    bit                 last_bmp_ok = 1'b0;
    logic [TOTAL_W-1:0] cur_total = '0;
    logic [SHIFT_W-1:0] cur_shift = SHIFT_RESET;
    logic [TENT_W-1:0]  cur_tent = '0;
    logic [TBO_W-1:0]   cur_tbo = '0;

    t_rsp translation_q[$];
    int   errors = 0;
    int   req_gap_pct = 27;
    int   rsp_stall_pct = 27;
    bit   rsp_hold = 1'b0;

    function automatic void raise_free(input longint unsigned v);
        if (DSEC_W'(v) > free_ptr) begin
            free_ptr = DSEC_W'(v);
        end
    endfunction

    function automatic t_rsp translate_request(input t_req r);
        t_rsp res;
        longint unsigned blk, bmp, blkno, offs, run, entry;
        res = '0;
        res.status = STS_OK;
        blk = 64'd1 << cur_shift;
        if (cur_shift < 5'd3) begin
            bmp = 0;
        end else if (cur_shift <= 5'd12) begin
            bmp = 1;
        end else begin
            bmp = 64'd1 << (cur_shift - 5'd12);
        end

        if (r.action == ACT_LOAD) begin
            blk_table[r.load_index] = r.load_value;
            loaded[r.load_index] = 1'b1;
            // first whole sector after the table
            raise_free((64'(cur_tbo) + 4 * 64'(cur_tent) + 511) >> 9);
            if (r.load_value != UNALLOC) begin
                raise_free(64'(r.load_value) + bmp + blk);
            end
            return res;
        end
        if (r.action == ACT_BAD || r.sector >= cur_total) begin
            res.status = STS_RANGE;
            return res;
        end

        blkno = 64'(r.sector) >> cur_shift;
        offs = 64'(r.sector) & (blk - 1);
        run = blk - offs;
        if (run > 64'(r.request)) begin
            run = 64'(r.request);
        end
        res.run_sectors = RUN_W'(run);

        if (blkno >= 64'(cur_tent) || blkno >= TBL_DEPTH) begin
            if (r.action == ACT_READ) begin
                res.status = STS_UNALLOC;
            end else begin
                res.status = STS_RANGE;
                res.run_sectors = '0;
            end
            return res;
        end

        entry = 64'(blk_table[blkno]);
        if (entry != 64'(UNALLOC)) begin
            res.data_sector = DSEC_W'(entry + bmp + offs);
            res.bitmap_sector = DSEC_W'(entry);
            if (r.action == ACT_WRITE && (!last_bmp_ok || last_bmp != DSEC_W'(entry))) begin
                res.write_bitmap = 1'b1;
                last_bmp = DSEC_W'(entry);
                last_bmp_ok = 1'b1;
            end
            return res;
        end
        if (r.action == ACT_READ) begin
            res.status = STS_UNALLOC;
            return res;
        end
        // no table entry can point past the 32-bit range
        if (free_ptr >= DSEC_W'(UNALLOC)) begin
            res.status = STS_RANGE;
            res.run_sectors = '0;
            return res;
        end
        entry = 64'(free_ptr);
        blk_table[blkno] = VAL_W'(entry);
        free_ptr = DSEC_W'(entry + blk + bmp);
        res.data_sector = DSEC_W'(entry + bmp + offs);
        res.write_bitmap = 1'b1;
        res.bitmap_sector = DSEC_W'(entry);
        res.block_allocated = 1'b1;
        res.table_index = IDX_W'(blkno);
        res.table_value = VAL_W'(entry);
        res.footer_sector = free_ptr;
        return res;
    endfunction

    // a lookup that would hit an entry never loaded becomes a load of that entry
    function automatic t_req legalize(input t_req r);
        longint unsigned blkno;
        blkno = 64'(r.sector) >> cur_shift;
        if ((r.action == ACT_READ || r.action == ACT_WRITE) && r.sector < cur_total &&
            blkno < 64'(cur_tent) && blkno < TBL_DEPTH && !loaded[blkno]) begin
            r.action = ACT_LOAD;
            r.load_index = IDX_W'(blkno);
            r.load_value = $urandom_range(0, 1) ? UNALLOC : $urandom_range(0, 1 << 22);
        end
        return r;
    endfunction

    function automatic t_req req_item(input t_action a, input logic [SECTOR_W-1:0] s,
                                      input logic [RUN_W-1:0] n, input logic [IDX_W-1:0] li,
                                      input logic [VAL_W-1:0] lv);
        t_req r;
        r.action = a;
        r.sector = s;
        r.request = n;
        r.load_index = li;
        r.load_value = lv;
        return r;
    endfunction

    function automatic t_req rand_item();
        t_req r;
        int unsigned pick, span, near;
        longint unsigned blk;
        blk = 64'd1 << cur_shift;
        span = (cur_tent < 13'd4096) ? 32'(cur_tent) : 32'(TBL_DEPTH);
        near = (span < 24) ? span : 24;

        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            r.action = ACT_LOAD;
        end else if (pick < 60) begin
            r.action = ACT_READ;
        end else if (pick < 96) begin
            r.action = ACT_WRITE;
        end else begin
            r.action = ACT_BAD;
        end

        // four draws in ten pick blocks near the start of the table so entries get reused
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            r.sector = 32'((64'($urandom_range(0, near + 1)) << cur_shift) +
                           (64'($urandom) & (blk - 1)));
        end else if (pick < 6) begin
            r.sector = 32'((64'($urandom_range(0, span + 1)) << cur_shift) +
                           (64'($urandom) & (blk - 1)));
        end else if (pick < 8) begin
            r.sector = (cur_total != 0) ? $urandom_range(0, cur_total - 1) : $urandom;
        end else if (pick < 9) begin
            r.sector = 32'(cur_total) + $urandom_range(0, 3);
        end else begin
            r.sector = $urandom;
        end

        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            r.request = '0;
        end else if (pick == 1) begin
            r.request = 16'hFFFF;
        end else if (pick < 10) begin
            r.request = RUN_W'($urandom_range(1, 16));
        end else begin
            r.request = RUN_W'($urandom_range(1, 65535));
        end

        if (span != 0 && $urandom_range(0, 9) < 7) begin
            r.load_index = IDX_W'($urandom_range(0, near - 1 + (near == 0)));
        end else begin
            r.load_index = IDX_W'($urandom_range(0, TBL_DEPTH - 1));
        end

        pick = $urandom_range(0, 19);
        if (pick < 6) begin
            r.load_value = UNALLOC;
        end else if (pick < 17) begin
            r.load_value = $urandom_range(0, 1 << 22);
        end else begin
            r.load_value = $urandom_range(0, 32'h7FFF_FFFF);
        end
        return r;
    endfunction

    task automatic send_req(input t_req item);
        t_req r;
        r = legalize(item);
        translation_q.push_back(translate_request(r));
        if ($urandom_range(0, 99) < req_gap_pct) begin
            req_bus.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < req_gap_pct);
        end
        req_bus.valid           <= 1'b1;
        req_bus.action          <= r.action;
        req_bus.sector          <= r.sector;
        req_bus.request_sectors <= r.request;
        req_bus.load_index      <= r.load_index;
        req_bus.load_value      <= r.load_value;
        do @(posedge i_clk); while (!req_bus.ready);
    endtask

    // stop offering and wait for every outstanding result
    task automatic finish_phase();
        req_bus.valid <= 1'b0;
        while (translation_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DAT_W-1:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do @(posedge i_clk); while (!cfg_bus.ready);
        case (idx)
            CFG_TOTAL: cur_total = val[TOTAL_W-1:0];
            CFG_SHIFT: cur_shift = val[SHIFT_W-1:0];
            CFG_TENT:  cur_tent  = val[TENT_W-1:0];
            CFG_TBO:   cur_tbo   = val[TBO_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [TOTAL_W-1:0] total, input logic [SHIFT_W-1:0] shift,
                              input logic [TENT_W-1:0] tent, input logic [TBO_W-1:0] tbo);
        write_reg(CFG_TOTAL, CFG_DAT_W'(total));
        write_reg(CFG_SHIFT, CFG_DAT_W'(shift));
        write_reg(CFG_TENT, CFG_DAT_W'(tent));
        write_reg(CFG_TBO, CFG_DAT_W'(tbo));
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic random_phase(input logic [TOTAL_W-1:0] total, input logic [SHIFT_W-1:0] shift,
                                input logic [TENT_W-1:0] tent, input logic [TBO_W-1:0] tbo,
                                input int count);
        set_config(total, shift, tent, tbo);
        repeat (count) send_req(rand_item());
        finish_phase();
    endtask

    // default registers: zero disk size, so every lookup is out of range
    task automatic test_reset_defaults();
        send_req(req_item(ACT_READ, 32'd0, 16'd1, 12'd0, 32'd0));
        send_req(req_item(ACT_WRITE, 32'd0, 16'd1, 12'd0, 32'd0));
        send_req(req_item(ACT_BAD, 32'd0, 16'd1, 12'd0, 32'd0));
        send_req(req_item(ACT_LOAD, 32'd0, 16'd1, 12'd4095, 32'd0));
        finish_phase();
    endtask

    task automatic test_directed_lookup();
        set_config(28'd50000, 5'd3, 13'd16, 48'd1000);
        send_req(req_item(ACT_LOAD, 32'd0, 16'd1, 12'd0, UNALLOC));
        send_req(req_item(ACT_LOAD, 32'd0, 16'd1, 12'd1, 32'd100));
        send_req(req_item(ACT_LOAD, 32'd0, 16'd1, 12'd2, UNALLOC));
        send_req(req_item(ACT_LOAD, 32'd0, 16'd1, 12'd3, 32'd0));
        // read of an unallocated block, then of an allocated one
        send_req(req_item(ACT_READ, 32'd5, 16'd16, 12'd0, 32'd0));
        send_req(req_item(ACT_READ, 32'd9, 16'hFFFF, 12'd0, 32'd0));
        // bitmap rewrite only when the block changes
        send_req(req_item(ACT_WRITE, 32'd9, 16'd1, 12'd0, 32'd0));
        send_req(req_item(ACT_WRITE, 32'd15, 16'hFFFF, 12'd0, 32'd0));
        // allocation at the free pointer
        send_req(req_item(ACT_WRITE, 32'd3, 16'd0, 12'd0, 32'd0));
        send_req(req_item(ACT_READ, 32'd3, 16'd2, 12'd0, 32'd0));
        send_req(req_item(ACT_WRITE, 32'd20, 16'd8, 12'd0, 32'd0));
        send_req(req_item(ACT_WRITE, 32'd24, 16'd5, 12'd0, 32'd0));
        // block index past the table
        send_req(req_item(ACT_READ, 32'd128, 16'd4, 12'd0, 32'd0));
        send_req(req_item(ACT_WRITE, 32'd128, 16'd4, 12'd0, 32'd0));
        send_req(req_item(ACT_READ, 32'd49999, 16'd4, 12'd0, 32'd0));
        // sector past the disk and unknown action
        send_req(req_item(ACT_READ, 32'd50000, 16'd4, 12'd0, 32'd0));
        send_req(req_item(ACT_WRITE, 32'hFFFF_FFFF, 16'd4, 12'hFFF, 32'hFFFF_FFFF));
        send_req(req_item(ACT_BAD, 32'd0, 16'd4, 12'd0, 32'd0));
        finish_phase();
    endtask

    task automatic test_random_configs();
        random_phase(28'd20000, 5'd3, 13'd64, 48'd0, 140);
        random_phase(28'd1048576, 5'd9, 13'd2100, 48'd12345, 140);
        random_phase(28'd100000, 5'd12, 13'd30, 48'd2560, 140);
        // a long stretch with no idling on either side
        req_gap_pct = 0;
        rsp_stall_pct <= 0;
        random_phase(28'hFFF_FFFF, 5'd16, 13'd4096, 48'($urandom), 140);
        req_gap_pct = 27;
        rsp_stall_pct <= 27;
        random_phase(28'hFFF_FFFF, 5'd14, 13'd8191, 48'd0, 140);
        random_phase(28'd1000, 5'd4, 13'd0, 48'd7, 140);
        repeat (2) begin
            random_phase(TOTAL_W'($urandom_range(1, 1 << 24)), SHIFT_W'($urandom_range(3, 16)),
                         TENT_W'($urandom_range(1, 300)), TBO_W'($urandom_range(0, 1 << 20)),
                         140);
        end
    endtask

    task automatic test_output_backpressure();
        set_config(28'd60000, 5'd5, 13'd100, 48'd4096);
        fork
            begin
                rsp_hold <= 1'b1;
                repeat (300) @(posedge i_clk);
                rsp_hold <= 1'b0;
            end
        join_none
        req_gap_pct = 0;
        repeat (60) send_req(rand_item());
        req_gap_pct = 27;
        // sender goes quiet until everything is back
        finish_phase();
        repeat (60) send_req(rand_item());
        finish_phase();
    endtask

    task automatic test_odd_block_shifts();
        random_phase(28'd5000, 5'd0, 13'd8191, 48'd0, 40);
        random_phase(28'd3000, 5'd1, 13'd200, 48'd0, 40);
        random_phase(28'd3000, 5'd2, 13'd100, 48'd600, 40);
        random_phase(28'hFFF_FFFF, 5'd31, 13'd1, 48'd0, 40);
    endtask

    // table past the 32-bit range pushes the free pointer beyond any entry
    task automatic test_free_pointer_full();
        set_config(28'hFFF_FFFF, 5'd16, 13'd4096, 48'hFFFF_FFFF_FFFF);
        send_req(req_item(ACT_LOAD, 32'd0, 16'd1, 12'd0, UNALLOC));
        send_req(req_item(ACT_WRITE, 32'd5, 16'd9, 12'd0, 32'd0));
        send_req(req_item(ACT_READ, 32'd5, 16'd9, 12'd0, 32'd0));
        send_req(req_item(ACT_LOAD, 32'd0, 16'd1, 12'd1, 32'hFFFF_FFFE));
        send_req(req_item(ACT_READ, 32'd65543, 16'hFFFF, 12'd0, 32'd0));
        send_req(req_item(ACT_WRITE, 32'd65543, 16'd1, 12'd0, 32'd0));
        repeat (40) send_req(rand_item());
        finish_phase();
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // result side: compare each transfer, then pick next ready
    always @(posedge i_clk) begin : result_check
        t_rsp want;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (translation_q.size() == 0) begin
                $display("%0t: result with no request pending, expected none actual status %0h",
                         $time, rsp_bus.status);
                errors++;
            end else begin
                want = translation_q.pop_front();
                check_field("status", want.status, rsp_bus.status);
                check_field("data_sector", want.data_sector, rsp_bus.data_sector);
                check_field("run_sectors", want.run_sectors, rsp_bus.run_sectors);
                check_field("write_bitmap", want.write_bitmap, rsp_bus.write_bitmap);
                check_field("bitmap_sector", want.bitmap_sector, rsp_bus.bitmap_sector);
                check_field("block_allocated", want.block_allocated, rsp_bus.block_allocated);
                check_field("table_index", want.table_index, rsp_bus.table_index);
                check_field("table_value", want.table_value, rsp_bus.table_value);
                check_field("footer_sector", want.footer_sector, rsp_bus.footer_sector);
            end
        end
        if (rsp_hold) begin
            rsp_bus.ready <= 1'b0;
        end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
        end
    end

    initial begin
        #(5_000_000);
        $display("sparse_disk_block_translator_top test failed");
        $finish;
    end

    initial begin
        req_bus.valid = 1'b0;
        req_bus.action = '0;
        req_bus.sector = '0;
        req_bus.request_sectors = '0;
        req_bus.load_index = '0;
        req_bus.load_value = '0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = '0;
        cfg_bus.data = '0;
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_directed_lookup();
        test_random_configs();
        test_output_backpressure();
        test_odd_block_shifts();
        test_free_pointer_full();

        finish_phase();
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("sparse_disk_block_translator_top test passed");
        end else begin
            $display("sparse_disk_block_translator_top test failed");
        end
        $finish;
    end

endmodule

// ===== sparse_disk_block_translator_top.f =====
+incdir+design
design/sdbt_pkg.sv
design/sdbt_ifs.sv
design/sdbt_ram.sv
design/sdbt_ctrl.sv
design/sdbt_dpath.sv
design/sparse_disk_block_translator_top.sv
tb/sparse_disk_block_translator_top_tb.sv
